>>> rtl/aabb_segment_overlap_assert.svh
// ----------------------------------------------------------------------------
// aabb segment overlap assertion macros
// concurrent assertion wrappers, empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef AABB_SEGMENT_OVERLAP_ASSERT_SVH
`define AABB_SEGMENT_OVERLAP_ASSERT_SVH
`ifndef SYNTHESIS
`define AABB_ASSERT_NOW(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("aabb_segment_overlap: same-cycle check failed");
`define AABB_ASSERT_NEXT(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("aabb_segment_overlap: next-cycle check failed");
`define AABB_ASSERT_RST(lbl, clk, rst, c) \
   lbl: assert property (@(posedge clk) (rst) |=> (c)) \
      else $error("aabb_segment_overlap: reset check failed");
`else
`define AABB_ASSERT_NOW(lbl, clk, rst, a, c)
`define AABB_ASSERT_NEXT(lbl, clk, rst, a, c)
`define AABB_ASSERT_RST(lbl, clk, rst, c)
`endif
`endif

>>> rtl/aabb_pkg.sv
// ----------------------------------------------------------------------------
// aabb_pkg
// widths, types and constants shared by the segment versus box overlap block
// ----------------------------------------------------------------------------
package aabb_pkg;

   localparam int COORD_W    = 32;
   localparam int HALF_W     = 31;
   localparam int EPS_W      = 16;
   localparam int S_W        = 34;
   localparam int D_W        = 33;
   localparam int MAG_W      = 33;
   localparam int FACE_W     = 34;
   localparam int PROD_W     = S_W + D_W;
   localparam int DIFF_W     = PROD_W + 1;
   localparam int HP_W       = HALF_W + MAG_W;
   localparam int RHS_W      = HP_W + 2;
   localparam int CMP_W      = DIFF_W + 1;
   localparam int REQ_DATA_W = 384;
   localparam int RSP_DATA_W = 8;

   localparam logic [EPS_W-1:0] EPS_RESET = 16'd1;

   typedef logic signed [S_W-1:0]    sval_type;
   typedef logic signed [D_W-1:0]    dval_type;
   typedef logic [HALF_W-1:0]        half_type;
   typedef logic [MAG_W-1:0]         mag_type;
   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic signed [DIFF_W-1:0] diff_type;
   typedef logic [HP_W-1:0]          hp_type;
   typedef logic [RHS_W-1:0]         rhs_type;

   typedef struct packed {
      logic s2;
      logic s3;
   } pipe_en_type;

endpackage

>>> rtl/aabb_cross_axis.sv
// ----------------------------------------------------------------------------
// aabb_cross_axis
// one cross-axis separating test: products, then difference and bound,
// then the reject flag from the stage-3 registers
// ----------------------------------------------------------------------------
module aabb_cross_axis
   import aabb_pkg::*;
(
   input  logic        clock,
   input  pipe_en_type en,
   input  sval_type    sa,
   input  dval_type    db,
   input  sval_type    sb,
   input  dval_type    da,
   input  half_type    ha,
   input  mag_type     pb,
   input  half_type    hb,
   input  mag_type     pa,
   output logic        reject
);

   prod_type p1_ff, p1_in;
   prod_type p2_ff, p2_in;
   hp_type   q1_ff, q1_in;
   hp_type   q2_ff, q2_in;
   diff_type diff_ff, diff_in;
   rhs_type  rhs_ff, rhs_in;

   logic signed [CMP_W-1:0] diff_x;
   logic signed [CMP_W-1:0] rhs_x;
   logic signed [CMP_W-1:0] sum_x;

   always_comb begin
      p1_in = PROD_W'(sa) * PROD_W'(db);
      p2_in = PROD_W'(sb) * PROD_W'(da);
      q1_in = HP_W'(ha) * HP_W'(pb);
      q2_in = HP_W'(hb) * HP_W'(pa);
   end

   always_ff @(posedge clock) begin
      if (en.s2) begin
         p1_ff <= p1_in;
         p2_ff <= p2_in;
         q1_ff <= q1_in;
         q2_ff <= q2_in;
      end
   end

   always_comb begin
      diff_in = DIFF_W'(p1_ff) - DIFF_W'(p2_ff);
      rhs_in  = {(RHS_W-1)'(q1_ff) + (RHS_W-1)'(q2_ff), 1'b0};
   end

   always_ff @(posedge clock) begin
      if (en.s3) begin
         diff_ff <= diff_in;
         rhs_ff  <= rhs_in;
      end
   end

   // |diff| > rhs  <=>  diff > rhs or diff < -rhs
   always_comb begin
      diff_x = CMP_W'(diff_ff);
      rhs_x  = $signed({{(CMP_W-RHS_W){1'b0}}, rhs_ff});
      sum_x  = diff_x + rhs_x;
      reject = (diff_x > rhs_x) || sum_x[CMP_W-1];
   end

endmodule

>>> rtl/aabb_segment_overlap.sv
// ----------------------------------------------------------------------------
// aabb_segment_overlap
// segment versus axis-aligned box overlap by separating axis test
// ----------------------------------------------------------------------------
// req_* carries one query per transaction: box center, half extents, segment
// start and end. rsp_* returns one overlap flag per query, in order.
// csr_we/csr_wdata write the cross-axis epsilon (reset value 1); write it
// only while no query is in flight.
// a query accepted at one clock edge reaches rsp_tvalid through the face
// tests at the accepting edge, then products, difference and bound, and
// the output register.
// throughput: one query per cycle while rsp_tready does not stall; each stage
// of the four-stage pipeline holds one query and has its own valid bit.
// a stalled rsp_tready holds the result; earlier stages keep filling their
// empty slots, and req_tready drops only once every stage is full.
// reset clears all valid bits and sets the epsilon to 1.
// ----------------------------------------------------------------------------
`include "aabb_segment_overlap_assert.svh"

module aabb_segment_overlap
   import aabb_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [EPS_W-1:0]      csr_wdata,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // center x,y,z (32 each), half x,y,z (31 each), start x,y,z, end x,y,z
   // (32 each), 3 zero pad bits
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // overlaps (1), 7 zero pad bits
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic [EPS_W-1:0] eps_ff;

   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic ready2, ready3, ready4;
   pipe_en_type en;

   logic signed [COORD_W-1:0] cen [3];
   logic signed [COORD_W-1:0] sta [3];
   logic signed [COORD_W-1:0] fin [3];
   half_type                  hin [3];

   sval_type s_in [3];
   dval_type d_in [3];
   mag_type  smag [3];
   mag_type  dmag [3];
   mag_type  p_in [3];
   logic [FACE_W-1:0] bound [3];
   logic face_rej_in;

   sval_type s_ff [3];
   dval_type d_ff [3];
   half_type h_ff [3];
   mag_type  p_ff [3];
   logic face_rej1_ff, face_rej2_ff, face_rej3_ff;
   logic overlap_ff, overlap_in;
   logic [2:0] cross_rej;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         cen[i] = req_tdata[i*COORD_W +: COORD_W];
         hin[i] = req_tdata[3*COORD_W + i*HALF_W +: HALF_W];
         sta[i] = req_tdata[3*COORD_W + 3*HALF_W + i*COORD_W +: COORD_W];
         fin[i] = req_tdata[6*COORD_W + 3*HALF_W + i*COORD_W +: COORD_W];
      end
   end

   always_comb begin
      face_rej_in = 1'b0;
      for (int i = 0; i < 3; i++) begin
         s_in[i]  = S_W'(sta[i]) + S_W'(fin[i]) - (S_W'(cen[i]) <<< 1);
         d_in[i]  = D_W'(sta[i]) - D_W'(fin[i]);
         smag[i]  = s_in[i][S_W-1] ? MAG_W'(-s_in[i]) : MAG_W'(s_in[i]);
         dmag[i]  = d_in[i][D_W-1] ? MAG_W'(-d_in[i]) : MAG_W'(d_in[i]);
         bound[i] = {2'b00, hin[i], 1'b0} + FACE_W'(dmag[i]);
         p_in[i]  = dmag[i] + MAG_W'({eps_ff, 1'b0});
         if (FACE_W'(smag[i]) > bound[i]) begin
            face_rej_in = 1'b1;
         end
      end
   end

   assign ready4     = !v4_ff || rsp_tready;
   assign ready3     = !v3_ff || ready4;
   assign ready2     = !v2_ff || ready3;
   assign req_tready = !v1_ff || ready2;
   assign en.s2      = v1_ff && ready2;
   assign en.s3      = v2_ff && ready3;

   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff <= EPS_RESET;
      end else if (csr_we) begin
         eps_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            v1_ff <= req_tvalid;
         end
         if (ready2) begin
            v2_ff <= v1_ff;
         end
         if (ready3) begin
            v3_ff <= v2_ff;
         end
         if (ready4) begin
            v4_ff <= v3_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         for (int i = 0; i < 3; i++) begin
            s_ff[i] <= s_in[i];
            d_ff[i] <= d_in[i];
            h_ff[i] <= hin[i];
            p_ff[i] <= p_in[i];
         end
         face_rej1_ff <= face_rej_in;
      end
      if (en.s2) begin
         face_rej2_ff <= face_rej1_ff;
      end
      if (en.s3) begin
         face_rej3_ff <= face_rej2_ff;
      end
      if (ready4 && v3_ff) begin
         overlap_ff <= overlap_in;
      end
   end

   // axis pairs (y,z), (z,x), (x,y)
   aabb_cross_axis u_cross_x (
      .clock  (clock),
      .en     (en),
      .sa     (s_ff[1]),
      .db     (d_ff[2]),
      .sb     (s_ff[2]),
      .da     (d_ff[1]),
      .ha     (h_ff[1]),
      .pb     (p_ff[2]),
      .hb     (h_ff[2]),
      .pa     (p_ff[1]),
      .reject (cross_rej[0])
   );

   aabb_cross_axis u_cross_y (
      .clock  (clock),
      .en     (en),
      .sa     (s_ff[2]),
      .db     (d_ff[0]),
      .sb     (s_ff[0]),
      .da     (d_ff[2]),
      .ha     (h_ff[2]),
      .pb     (p_ff[0]),
      .hb     (h_ff[0]),
      .pa     (p_ff[2]),
      .reject (cross_rej[1])
   );

   aabb_cross_axis u_cross_z (
      .clock  (clock),
      .en     (en),
      .sa     (s_ff[0]),
      .db     (d_ff[1]),
      .sb     (s_ff[1]),
      .da     (d_ff[0]),
      .ha     (h_ff[0]),
      .pb     (p_ff[1]),
      .hb     (h_ff[1]),
      .pa     (p_ff[0]),
      .reject (cross_rej[2])
   );

   assign overlap_in = !face_rej3_ff && (cross_rej == 3'b000);

   assign rsp_tvalid = v4_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-1){1'b0}}, overlap_ff};

   `AABB_ASSERT_NEXT(a_accept_fills_stage1, clock, reset, req_tvalid && req_tready, v1_ff)
   `AABB_ASSERT_NEXT(a_stage1_holds, clock, reset, v1_ff && !ready2, v1_ff && $stable(face_rej1_ff))
   `AABB_ASSERT_NEXT(a_stage3_to_output, clock, reset, v3_ff && ready4, rsp_tvalid)
   `AABB_ASSERT_NEXT(a_csr_write, clock, reset, csr_we, eps_ff == $past(csr_wdata))
   `AABB_ASSERT_NOW(a_full_blocks_input, clock, reset, v1_ff && v2_ff && v3_ff && v4_ff && !rsp_tready, !req_tready)
   `AABB_ASSERT_RST(a_reset_clears, clock, reset, !rsp_tvalid)

endmodule

>>> tb/aabb_segment_overlap_tb.sv
// ----------------------------------------------------------------------------
// aabb_segment_overlap_tb
// drives segment versus box queries through the req stream, predicts the
// overlap flag of each accepted query with exact wide arithmetic and checks
// every rsp transaction in order; covers several epsilon settings, random
// stalls on both sides, a long response hold-off and a full drain
// ----------------------------------------------------------------------------
module aabb_segment_overlap_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import aabb_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int HOLD_CYCLES  = 120;
   localparam int PHASE_ITEMS  = 250;
   localparam int PHASE_COUNT  = 5;
   localparam int FLUSH_CYCLES = 12;

   typedef logic signed [79:0] wide_t;

   typedef struct {
      int          center[3];
      int unsigned half[3];
      int          p0[3];
      int          p1[3];
   } query_t;

   class overlap_scoreboard;
      logic [EPS_W-1:0] eps;
      bit               expected_hits[$];
      int               errors;

      function new();
         eps = EPS_RESET;
         errors = 0;
      endfunction

      function wide_t wabs(wide_t v);
         return (v < 0) ? -v : v;
      endfunction

      function bit predict_overlap(query_t q);
         wide_t s[3], d[3], h[3], p[3];
         wide_t a0, a1, c, e, lhs, rhs;
         int    i, j;
         e = eps;
         for (i = 0; i < 3; i++) begin
            a0 = q.p0[i];
            a1 = q.p1[i];
            c = q.center[i];
            h[i] = q.half[i] & 32'h7fff_ffff;
            s[i] = a0 + a1 - 2 * c;
            d[i] = a0 - a1;
            if (wabs(s[i]) > 2 * h[i] + wabs(d[i])) begin
               return 1'b0;
            end
            p[i] = wabs(d[i]) + 2 * e;
         end
         for (i = 0; i < 3; i++) begin
            j = (i + 1) % 3;
            lhs = wabs(s[i] * d[j] - s[j] * d[i]);
            rhs = 2 * (h[i] * p[j] + h[j] * p[i]);
            if (lhs > rhs) begin
               return 1'b0;
            end
         end
         return 1'b1;
      endfunction

      function void note_query(query_t q);
         expected_hits.push_back(predict_overlap(q));
      endfunction

      function void check_flag(logic [RSP_DATA_W-1:0] data);
         bit want;
         if (expected_hits.size() == 0) begin
            $error("overlaps: no transaction expected, actual %0d", data[0]);
            errors++;
            return;
         end
         want = expected_hits.pop_front();
         if (data[0] !== want) begin
            $error("overlaps mismatch: expected %0d actual %0d", want, data[0]);
            errors++;
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [EPS_W-1:0]      csr_wdata;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   overlap_scoreboard sb = new();
   bit tx_idle_on = 1'b1;
   bit rx_stall_on = 1'b1;
   bit rx_hold = 1'b0;

   aabb_segment_overlap dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   function automatic logic [REQ_DATA_W-1:0] pack_query(query_t q);
      logic [REQ_DATA_W-1:0] v;
      int                    i;
      v = '0;
      for (i = 0; i < 3; i++) begin
         v[COORD_W*i +: COORD_W] = q.center[i];
         v[3*COORD_W + HALF_W*i +: HALF_W] = q.half[i][HALF_W-1:0];
         v[3*COORD_W + 3*HALF_W + COORD_W*i +: COORD_W] = q.p0[i];
         v[6*COORD_W + 3*HALF_W + COORD_W*i +: COORD_W] = q.p1[i];
      end
      return v;
   endfunction

   function automatic query_t set_query(int cx, int cy, int cz,
                                        int unsigned hx, int unsigned hy,
                                        int unsigned hz,
                                        int ax, int ay, int az,
                                        int bx, int by, int bz);
      query_t q;
      q.center = '{cx, cy, cz};
      q.half   = '{hx & 32'h7fff_ffff, hy & 32'h7fff_ffff, hz & 32'h7fff_ffff};
      q.p0     = '{ax, ay, az};
      q.p1     = '{bx, by, bz};
      return q;
   endfunction

   // mostly queries near the box, some full-range noise
   function automatic query_t make_random_query();
      query_t q;
      int     pick, k, i;
      pick = $urandom_range(0, 99);
      for (i = 0; i < 3; i++) begin
         if (pick < 15) begin
            q.center[i] = $urandom;
            q.half[i]   = $urandom & 32'h7fff_ffff;
            q.p0[i]     = $urandom;
            q.p1[i]     = $urandom;
         end else if (pick < 55) begin
            k = $urandom_range(1, 30);
            q.center[i] = $urandom;
            q.half[i]   = $urandom & ((32'h1 << (k + 1)) - 1);
            q.p0[i]     = q.center[i] + (int'($urandom) >>> (30 - k));
            q.p1[i]     = q.center[i] + (int'($urandom) >>> (30 - k));
         end else begin
            k = $urandom_range(1, 10);
            q.center[i] = int'($urandom) >>> (31 - k);
            q.half[i]   = $urandom_range(0, 1 << k);
            q.p0[i]     = int'($urandom) >>> (31 - k);
            q.p1[i]     = int'($urandom) >>> (31 - k);
         end
      end
      if ($urandom_range(0, 7) == 0) begin
         q.p1 = q.p0;
      end
      return q;
   endfunction

   task automatic send_query(query_t q);
      req_tdata  <= pack_query(q);
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      sb.note_query(q);
   endtask

   task automatic tx_gap();
      if (tx_idle_on && $urandom_range(0, 2) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (sb.expected_hits.size() != 0) @(posedge clock);
      repeat (FLUSH_CYCLES) @(posedge clock);
   endtask

   task automatic write_epsilon(logic [EPS_W-1:0] value);
      wait_idle();
      csr_wdata <= value;
      csr_we    <= 1'b1;
      @(posedge clock);
      csr_we    <= 1'b0;
      sb.eps = value;
   endtask

   task automatic run_directed();
      localparam int MX = 32'h7fff_ffff;
      localparam int MN = 32'h8000_0000;
      query_t list[$];
      int     i;
      list.push_back(set_query(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      list.push_back(set_query(0, 0, 0, 0, 0, 0, 1, 0, 0, 1, 0, 0));
      // point touching a face, then just outside it
      list.push_back(set_query(0, 0, 0, 5, 5, 5, 5, 0, 0, 5, 0, 0));
      list.push_back(set_query(0, 0, 0, 5, 5, 5, 6, 0, 0, 6, 0, 0));
      list.push_back(set_query(0, 0, 0, 5, 5, 5, 0, 0, -5, 0, 0, -5));
      list.push_back(set_query(0, 0, 0, 4, 4, 4, -100, 0, 0, 100, 0, 0));
      // diagonal segments that clear a corner or graze it
      list.push_back(set_query(0, 0, 0, 4, 4, 4, 0, 10, 0, 10, 0, 0));
      list.push_back(set_query(0, 0, 0, 4, 4, 4, 0, 8, 0, 8, 0, 0));
      list.push_back(set_query(0, 0, 0, 4, 4, 4, 0, 0, 10, 0, 10, 0));
      list.push_back(set_query(0, 0, 0, 4, 4, 4, -10, 0, 0, 0, 0, -10));
      list.push_back(set_query(7, -3, 2, 4, 4, 4, 7, -13, 2, -3, -3, 2));
      // flat box
      list.push_back(set_query(0, 0, 0, 0, 4, 4, -3, 1, 1, 3, 1, 1));
      list.push_back(set_query(0, 0, 0, 0, 4, 4, 1, 1, 1, 3, 1, 1));
      // extreme coordinates
      list.push_back(set_query(MX, MX, MX, MX, MX, MX, MN, MN, MN, MN, MN, MN));
      list.push_back(set_query(MN, MN, MN, MX, MX, MX, MX, MX, MX, MX, MX, MX));
      list.push_back(set_query(0, 0, 0, MX, MX, MX, MN, MN, MN, MX, MX, MX));
      list.push_back(set_query(MN, MN, MN, MX, MX, MX, MN, MN, MN, MN, MN, MN));
      list.push_back(set_query(0, 0, 0, 0, 0, 0, MX, MX, MX, MN, MN, MN));
      list.push_back(set_query(MN, MX, MN, MX, MX, MX, MX, MN, MX, MN, MX, MN));
      list.push_back(set_query(MX, MX, MX, MX, MX, MX, MX, MX, MX, MX, MX, MX));
      list.push_back(set_query(MN, MN, MN, 0, 0, 0, MN, MN, MN, MN, MN, MN));
      list.push_back(set_query(0, 0, 0, MX, 0, MX, MX, MN, 0, MN, MX, 0));
      list.push_back(set_query(0, MN, 0, 1, 0, 1, MX, 0, MN, MN, 1, MX));
      for (i = 0; i < list.size(); i++) begin
         send_query(list[i]);
         tx_gap();
      end
   endtask

   initial begin
      forever begin
         if (rx_hold) begin
            rx_hold = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (rx_stall_on && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_flag(rsp_tdata);
      end
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("FAIL aabb_segment_overlap");
      $finish;
   end

   initial begin
      logic [EPS_W-1:0] eps_plan[PHASE_COUNT];
      int               phase, n;
      reset      <= 1'b1;
      csr_we     <= 1'b0;
      csr_wdata  <= '0;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      eps_plan = '{16'd0, 16'hffff, 16'($urandom_range(0, 65535)),
                   16'($urandom_range(0, 15)), 16'd1};
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // reset value of the epsilon is in force here
      run_directed();

      for (phase = 0; phase < PHASE_COUNT; phase++) begin
         write_epsilon(eps_plan[phase]);
         tx_idle_on  = (phase != PHASE_COUNT - 1);
         rx_stall_on = (phase != PHASE_COUNT - 1);
         for (n = 0; n < PHASE_ITEMS; n++) begin
            if (phase == 1 && n == 100) begin
               rx_hold = 1'b1;
               tx_idle_on = 1'b0;
            end
            if (phase == 1 && n == 140) begin
               tx_idle_on = 1'b1;
            end
            if (phase == 2 && n == 120) begin
               wait_idle();
            end
            send_query(make_random_query());
            tx_gap();
         end
      end

      wait_idle();
      if (sb.errors == 0) begin
         $display("PASS aabb_segment_overlap");
      end else begin
         $display("FAIL aabb_segment_overlap");
      end
      $finish;
   end

endmodule
